[design/wgtb_pkg.sv]
// ----------------------------------------------------------------------------
// wgtb_pkg
// Shared widths, register indexes, control struct and arctangent table for
// the windowed Goertzel tempo bin core.
// ----------------------------------------------------------------------------
`default_nettype none

package wgtb_pkg;

    localparam int MAX_BLOCK_DEF = 1024;

    localparam int Q_W    = 48;   // Goertzel state width
    localparam int ACC_W  = 72;   // serial multiplier accumulator width
    localparam int MPL_W  = 34;   // serial multiplier multiplier-operand width
    localparam int LEN_W  = 6;    // multiplier digit count width
    localparam int RED_W  = 30;   // reduced state width after block scaling
    localparam int C_W    = 33;   // floor(coefficient*b/2^16) width
    localparam int CR_W   = 40;   // rotator datapath width
    localparam int RAD_W  = 64;   // square root radicand width
    localparam int ROOT_W = 32;   // square root result width
    localparam int REM_W  = 35;   // square root partial remainder width
    localparam int DVD_W  = 52;   // magnitude dividend width
    localparam int S_MAX  = 18;   // largest block scaling shift
    localparam int CFG_W  = 19;   // widest configuration register

    localparam logic [1:0] CFG_COEF  = 2'd0;
    localparam logic [1:0] CFG_SINE  = 2'd1;
    localparam logic [1:0] CFG_BLEN  = 2'd2;
    localparam logic [1:0] CFG_POFF  = 2'd3;

    localparam logic [31:0] HALF_TURN = 32'd8388608;

    typedef struct packed {
        logic             start;
        logic             clear;   // zero the accumulator at start
        logic             neg;     // subtract the product
        logic [LEN_W-1:0] len;     // multiplier digits, top one is the sign
    } t_mul_ctl;

    function automatic logic [31:0] atan_lut(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:  v = 32'd2097152;
            4'd1:  v = 32'd1238021;
            4'd2:  v = 32'd654136;
            4'd3:  v = 32'd332050;
            4'd4:  v = 32'd166669;
            4'd5:  v = 32'd83416;
            4'd6:  v = 32'd41718;
            4'd7:  v = 32'd20860;
            4'd8:  v = 32'd10430;
            4'd9:  v = 32'd5215;
            4'd10: v = 32'd2608;
            4'd11: v = 32'd1304;
            4'd12: v = 32'd652;
            4'd13: v = 32'd326;
            4'd14: v = 32'd163;
            default: v = 32'd81;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/wgtb_smul.sv]
// ----------------------------------------------------------------------------
// wgtb_smul
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wgtb_smul import wgtb_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_mul_ctl                i_ctl,
    input  wire logic signed [ACC_W-1:0] i_mcand,
    input  wire logic signed [MPL_W-1:0] i_mplier,
    output logic signed [ACC_W-1:0]      o_acc,
    output logic                         o_done
);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_neg;
    logic [LEN_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_mcand;
    logic signed [MPL_W-1:0] r_mplier;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic                    last;

    always_comb begin
        last  = (r_cnt == '0);
        n_acc = r_acc;
        // the top digit carries negative weight
        if (r_mplier[0]) begin
            if (last ^ r_neg) begin
                n_acc = r_acc - r_mcand;
            end else begin
                n_acc = r_acc + r_mcand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy   <= 1'b1;
                r_neg    <= i_ctl.neg;
                r_cnt    <= i_ctl.len - LEN_W'(1);
                r_mcand  <= i_mcand;
                r_mplier <= i_mplier;
                if (i_ctl.clear) begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                r_acc    <= n_acc;
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >>> 1;
                r_cnt    <= r_cnt - LEN_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

[design/windowed_goertzel_tempo_bin_core.sv]
// ----------------------------------------------------------------------------
// windowed_goertzel_tempo_bin_core
// Goertzel detector for one tempo bin with windowed input, block magnitude
// and wrapped phase, built around one bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit first)             tuser/tlast
//  s_axis    in         novelty_sample[15:0], window_weight  none
//  m_axis    out        magnitude[15:0], phase[15:0]         none
//  cfg       in         write enable, index, 19-bit data     none
//
//  An item runs two serial multiplies of 17 and 19 digits on the shared
//  multiplier before the next ready. The item that closes a block adds up
//  to 18 scaling shifts, five multiplies, 32 square root steps, 52 divide
//  steps, 16 rotation steps (skipped for a zero vector) and an output step.
//  Reset clears state, count and registers but sets the block length to
//  1024; no clearing pass is needed. A waiting result does not block
//  input; a new result waits for the old.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_goertzel_tempo_bin_core import wgtb_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [31:0]       i_s_axis_tdata,   // novelty_sample, window_weight
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,   // magnitude, phase
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int NW = $clog2(MAX_BLOCK + 1);
    localparam int CW = (NW > 11) ? NW : 11;

    typedef enum logic [3:0] {
        S_IDLE, S_MXW, S_MQ, S_SCALE, S_MCB, S_MIM, S_MAA, S_MBB, S_MAC,
        S_SQRT, S_DIV, S_CORD, S_OUT
    } t_state;

    t_state r_state;

    logic signed [18:0]       r_coef;
    logic signed [17:0]       r_sine;
    logic [10:0]              r_blen;
    logic [15:0]              r_poff;

    logic signed [Q_W-1:0]    r_q1, r_q2;
    logic [NW-1:0]            r_cnt;
    logic [17:0]              r_xw;
    logic signed [Q_W-1:0]    r_a, r_b;
    logic [4:0]               r_s;
    logic signed [C_W-1:0]    r_c;
    logic signed [CR_W-1:0]   r_x, r_y;
    logic [31:0]              r_z;
    logic [RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [DVD_W-1:0]         r_dvd;
    logic [NW-1:0]            r_drem;
    logic [15:0]              r_quo;
    logic                     r_ovf;
    logic [15:0]              r_mag;
    logic [5:0]               r_it;

    logic                     r_out_valid;
    logic [15:0]              r_out_mag, r_out_ph;

    t_mul_ctl                 r_mctl;
    logic signed [ACC_W-1:0]  r_mcand;
    logic signed [MPL_W-1:0]  r_mplier;
    logic signed [ACC_W-1:0]  mul_acc;
    logic                     mul_done;

    wgtb_smul u_smul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_mctl),
        .i_mcand  (r_mcand),
        .i_mplier (r_mplier),
        .o_acc    (mul_acc),
        .o_done   (mul_done)
    );

    // effective block length
    logic [CW-1:0] blen_x;
    logic [NW-1:0] n_eff;
    always_comb begin
        blen_x = CW'(r_blen);
        if (blen_x == '0) begin
            n_eff = NW'(1);
        end else if (blen_x > CW'(MAX_BLOCK)) begin
            n_eff = NW'(MAX_BLOCK);
        end else begin
            n_eff = blen_x[NW-1:0];
        end
    end

    // recursion update
    logic signed [ACC_W-1:0] q_sum;
    logic signed [Q_W-1:0]   q0;
    logic [NW:0]             cnt_nx;
    always_comb begin
        q_sum = (mul_acc >>> 16) - ACC_W'(r_q2) + $signed({54'd0, r_xw});
        if (q_sum > $signed({{(ACC_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}})) begin
            q0 = {1'b0, {(Q_W-1){1'b1}}};
        end else if (q_sum < -$signed({{(ACC_W-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}})) begin
            q0 = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            q0 = q_sum[Q_W-1:0];
        end
        cnt_nx = {1'b0, r_cnt} + (NW+1)'(1);
    end

    logic in_rng;
    always_comb begin
        in_rng = (r_a >= -$signed(Q_W'(2**29))) && (r_a < $signed(Q_W'(2**29)))
              && (r_b >= -$signed(Q_W'(2**29))) && (r_b < $signed(Q_W'(2**29)));
    end

    // square root step: two radicand bits per cycle
    logic [REM_W+1:0] sq_t, sq_trial;
    logic             sq_ge;
    logic [REM_W-1:0] n_rem;
    logic [ROOT_W-1:0] n_root;
    always_comb begin
        sq_t     = {r_rem, r_rad[RAD_W-1 -: 2]};
        sq_trial = (REM_W+2)'({r_root, 2'b01});
        sq_ge    = (sq_t >= sq_trial);
        if (sq_ge) begin
            n_rem  = REM_W'(sq_t - sq_trial);
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = sq_t[REM_W-1:0];
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    // divide step: one quotient bit per cycle
    logic [NW:0]   dv_t;
    logic          dv_ge;
    logic [NW-1:0] n_drem;
    logic [15:0]   n_quo;
    logic          n_ovf;
    always_comb begin
        dv_t   = {r_drem, r_dvd[DVD_W-1]};
        dv_ge  = (dv_t >= {1'b0, n_eff});
        n_drem = dv_ge ? NW'(dv_t - {1'b0, n_eff}) : dv_t[NW-1:0];
        n_quo  = {r_quo[14:0], dv_ge};
        n_ovf  = r_ovf | r_quo[15];
    end

    // rotation step
    logic signed [CR_W-1:0] xs, ys, n_x, n_y;
    logic [31:0]            n_z;
    always_comb begin
        xs = r_x >>> r_it[3:0];
        ys = r_y >>> r_it[3:0];
        if (!r_y[CR_W-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_lut(r_it[3:0]);
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_lut(r_it[3:0]);
        end
    end

    logic signed [RED_W-1:0] a30, b30;
    logic signed [RAD_W-1:0] m2;
    logic signed [CR_W-1:0]  re_v;
    logic [31:0]             z_rnd;
    assign a30   = r_a[RED_W-1:0];
    assign b30   = r_b[RED_W-1:0];
    assign m2    = mul_acc[RAD_W-1:0];
    assign re_v  = CR_W'(a30) - CR_W'(mul_acc >>> 17);
    assign z_rnd = r_z + 32'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_coef      <= '0;
            r_sine      <= '0;
            r_blen      <= 11'd1024;
            r_poff      <= '0;
            r_q1        <= '0;
            r_q2        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_mctl      <= '0;
        end else begin
            r_mctl.start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COEF: r_coef <= i_cfg_data[18:0];
                    CFG_SINE: r_sine <= i_cfg_data[17:0];
                    CFG_BLEN: r_blen <= i_cfg_data[10:0];
                    CFG_POFF: r_poff <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_mctl   <= '{start: 1'b1, clear: 1'b1, neg: 1'b0,
                                      len: LEN_W'(17)};
                        r_mcand  <= ACC_W'({1'b0, i_s_axis_tdata[15:0]});
                        r_mplier <= MPL_W'({1'b0, i_s_axis_tdata[31:16]});
                        r_state  <= S_MXW;
                    end
                end
                S_MXW: begin
                    if (mul_done) begin
                        r_xw     <= 18'((mul_acc + ACC_W'(16384)) >>> 15);
                        r_mctl   <= '{start: 1'b1, clear: 1'b1, neg: 1'b0,
                                      len: LEN_W'(19)};
                        r_mcand  <= ACC_W'(r_q1);
                        r_mplier <= MPL_W'(r_coef);
                        r_state  <= S_MQ;
                    end
                end
                S_MQ: begin
                    if (mul_done) begin
                        r_q1 <= q0;
                        r_q2 <= r_q1;
                        if (cnt_nx >= {1'b0, n_eff}) begin
                            r_cnt   <= '0;
                            r_a     <= q0;
                            r_b     <= r_q1;
                            r_s     <= '0;
                            r_state <= S_SCALE;
                        end else begin
                            r_cnt   <= cnt_nx[NW-1:0];
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SCALE: begin
                    if (in_rng || r_s == 5'(S_MAX)) begin
                        r_mctl   <= '{start: 1'b1, clear: 1'b1, neg: 1'b0,
                                      len: LEN_W'(19)};
                        r_mcand  <= ACC_W'(b30);
                        r_mplier <= MPL_W'(r_coef);
                        r_state  <= S_MCB;
                    end else begin
                        r_a <= r_a >>> 1;
                        r_b <= r_b >>> 1;
                        r_s <= r_s + 5'd1;
                    end
                end
                S_MCB: begin
                    if (mul_done) begin
                        r_c      <= C_W'(mul_acc >>> 16);
                        r_x      <= re_v;
                        r_mctl   <= '{start: 1'b1, clear: 1'b1, neg: 1'b0,
                                      len: LEN_W'(18)};
                        r_mcand  <= ACC_W'(b30);
                        r_mplier <= MPL_W'(r_sine);
                        r_state  <= S_MIM;
                    end
                end
                S_MIM: begin
                    if (mul_done) begin
                        r_y      <= CR_W'(mul_acc >>> 16);
                        r_mctl   <= '{start: 1'b1, clear: 1'b1, neg: 1'b0,
                                      len: LEN_W'(RED_W)};
                        r_mcand  <= ACC_W'(a30);
                        r_mplier <= MPL_W'(a30);
                        r_state  <= S_MAA;
                    end
                end
                S_MAA: begin
                    if (mul_done) begin
                        r_mctl   <= '{start: 1'b1, clear: 1'b0, neg: 1'b0,
                                      len: LEN_W'(RED_W)};
                        r_mcand  <= ACC_W'(b30);
                        r_mplier <= MPL_W'(b30);
                        r_state  <= S_MBB;
                    end
                end
                S_MBB: begin
                    if (mul_done) begin
                        r_mctl   <= '{start: 1'b1, clear: 1'b0, neg: 1'b1,
                                      len: LEN_W'(RED_W)};
                        r_mcand  <= ACC_W'(r_c);
                        r_mplier <= MPL_W'(a30);
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mul_done) begin
                        // clamp a negative energy to zero
                        r_rad   <= m2[RAD_W-1] ? '0 : m2;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_it    <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_it   <= r_it + 6'd1;
                    if (r_it == 6'(ROOT_W - 1)) begin
                        r_dvd   <= DVD_W'(n_root) << (r_s + 5'd1);
                        r_drem  <= '0;
                        r_quo   <= '0;
                        r_ovf   <= 1'b0;
                        r_it    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd  <= r_dvd << 1;
                    r_drem <= n_drem;
                    r_quo  <= n_quo;
                    r_ovf  <= n_ovf;
                    r_it   <= r_it + 6'd1;
                    if (r_it == 6'(DVD_W - 1)) begin
                        r_mag <= n_ovf ? 16'hFFFF : n_quo;
                        r_it  <= '0;
                        if (r_x == '0 && r_y == '0) begin
                            r_z     <= '0;
                            r_state <= S_OUT;
                        end else if (r_x[CR_W-1]) begin
                            // turn the left half plane by half a turn
                            r_x     <= -r_x;
                            r_y     <= -r_y;
                            r_z     <= HALF_TURN;
                            r_state <= S_CORD;
                        end else begin
                            r_z     <= '0;
                            r_state <= S_CORD;
                        end
                    end
                end
                S_CORD: begin
                    r_x  <= n_x;
                    r_y  <= n_y;
                    r_z  <= n_z;
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd15) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_mag   <= r_mag;
                        r_out_ph    <= z_rnd[23:8] + r_poff;
                        r_out_valid <= 1'b1;
                        r_q1        <= '0;
                        r_q2        <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ph, r_out_mag};

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MXW || r_state == S_MQ || r_state == S_MCB ||
                      r_state == S_MIM || r_state == S_MAA || r_state == S_MBB ||
                      r_state == S_MAC))
        else $error("multiplier finished outside a multiply step");

    a_scale_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCALE |-> r_s <= 5'(S_MAX))
        else $error("block scaling shift out of range");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> {1'b0, r_cnt} < (NW+1)'(MAX_BLOCK))
        else $error("sample count reached the block limit while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_axis_tready) |=> $stable(r_out_ph))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[test/tb_windowed_goertzel_tempo_bin_core.sv]
// ----------------------------------------------------------------------------
// tb_windowed_goertzel_tempo_bin_core
// Self-checking bench for the Goertzel tempo bin core. A directed table covers
// the extremes, the register edge values and the mid-block length change. A
// random part follows, sweeping register settings and idle/stall phases.
// Every result is compared with a bit-exact fixed-point predictor or, for typed rows, with the table value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_windowed_goertzel_tempo_bin_core;
    import wgtb_pkg::*;

    localparam int SETTLE_CYC     = 400;    // one item plus the block-end pass
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint Q_HI       = 64'sd140737488355327;
    localparam longint Q_LO       = -64'sd140737488355328;
    localparam longint RED_LIM    = 64'sd536870912;
    localparam logic [31:0] ARCTAN [16] = '{
        32'd2097152, 32'd1238021, 32'd654136, 32'd332050, 32'd166669, 32'd83416,
        32'd41718, 32'd20860, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;
    typedef struct {
        t_row_kind       kind;
        logic [1:0]      idx;
        logic [CFG_W-1:0] val;
        logic [15:0]     smp;
        logic [15:0]     wgt;
        bit              typed;
        logic [15:0]     mag;
        logic [15:0]     ph;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [31:0]       i_s_axis_tdata = '0;   // novelty_sample, window_weight
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [31:0]       o_m_axis_tdata;        // magnitude, phase
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = CFG_COEF;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    // predictor copy of registers and state
    logic [18:0] bin_coef = '0;
    logic [17:0] bin_sine = '0;
    logic [10:0] bin_len  = 11'd1024;
    logic [15:0] bin_poff = '0;
    longint      q_one = 0, q_two = 0;
    int          taken = 0;

    logic [31:0] pending_bins [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    windowed_goertzel_tempo_bin_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [15:0] cordic_angle(input longint re, input longint im);
        longint x, y, nx;
        logic [31:0] z;
        z = 32'd0;
        x = re;
        y = im;
        if (re == 0 && im == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN[i];
            end
            x = nx;
        end
        z = (z + 32'd128) >> 8;
        return z[15:0];
    endfunction

    // Run one sample through the recursion; return 1 with the bin at block end.
    function automatic bit goertzel_step(input logic [15:0] smp, input logic [15:0] wgt,
                                         output logic [31:0] bin);
        longint coef, sn, xw, hi, lo, q0, a, b, c, m2, re, im, r, mag;
        int n, s;
        logic [15:0] ph;
        coef = longint'(signed'(bin_coef));
        sn = longint'(signed'(bin_sine));
        n = (bin_len == 0) ? 1 : ((bin_len > 1024) ? 1024 : int'(bin_len));
        bin = '0;
        xw = (longint'(smp) * longint'(wgt) + 16384) >>> 15;
        hi = q_one >>> 16;
        lo = q_one - hi * 65536;
        q0 = coef * hi + ((coef * lo) >>> 16) - q_two + xw;
        if (q0 > Q_HI) q0 = Q_HI;
        if (q0 < Q_LO) q0 = Q_LO;
        q_two = q_one;
        q_one = q0;
        taken++;
        if (taken < n) return 1'b0;
        s = 0;
        forever begin
            a = q_one >>> s;
            b = q_two >>> s;
            if ((a >= -RED_LIM && a < RED_LIM && b >= -RED_LIM && b < RED_LIM) || s >= 18)
                break;
            s++;
        end
        c = (coef * b) >>> 16;
        m2 = a * a + b * b - a * c;
        if (m2 < 0) m2 = 0;
        r = isqrt(m2);
        mag = (r << (s + 1)) / n;
        if (mag > 65535) mag = 65535;
        re = a - ((coef * b) >>> 17);
        im = (sn * b) >>> 16;
        ph = cordic_angle(re, im) + bin_poff;
        bin = {ph, mag[15:0]};
        q_one = 0;
        q_two = 0;
        taken = 0;
        return 1'b1;
    endfunction

    task automatic send_sample(input logic [15:0] smp, input logic [15:0] wgt,
                               input bit typed, input logic [31:0] typed_bin);
        logic [31:0] bin;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {wgt, smp};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (goertzel_step(smp, wgt, bin))
            pending_bins.push_back(typed ? typed_bin : bin);
    endtask

    // Hold input until every bin is out, then let the block go quiet.
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_COEF: bin_coef = val[18:0];
            CFG_SINE: bin_sine = val[17:0];
            CFG_BLEN: bin_len  = val[10:0];
            default:  bin_poff = val[15:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic reg_done;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_weight;
        return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    endfunction

    // pick a register value: mostly random, now and then an extreme
    function automatic logic [CFG_W-1:0] rand_reg(input logic [1:0] idx);
        int sel;
        sel = $urandom_range(7);
        case (idx)
            CFG_COEF: return (sel == 0) ? 19'h1FFFF : (sel == 1) ? 19'h60000 :
                             (sel == 2) ? 19'h40000 : 19'($urandom);
            CFG_SINE: return (sel == 0) ? 19'h10000 : (sel == 1) ? 19'h30000 :
                             19'($urandom);
            CFG_BLEN: return (sel == 0) ? 19'd0 : (sel == 1) ? 19'd1 :
                             19'($urandom_range(16, 2));
            default:  return (sel == 0) ? 19'h7FFF : (sel == 1) ? 19'h8000 :
                             19'($urandom);
        endcase
    endfunction

    t_row script [] = '{
        '{ROW_CFG,  CFG_COEF, 19'd0,      0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_SINE, 19'd0,      0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_POFF, 19'd0,      0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_BLEN, 19'd1,      0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd0,     16'd0,     1, 16'd0,     16'd0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd4096,  16'd32768, 1, 16'd8192,  16'd2},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd32768, 1, 16'd65535, 16'd0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd65535, 0, 0, 0},
        '{ROW_CFG,  CFG_COEF, 19'h1FFFF,  0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_SINE, 19'h10000,  0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_POFF, 19'h7FFF,   0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_BLEN, 19'd4,      0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd32768, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd0,     16'd32768, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd12345, 16'd20000, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd1,     0, 0, 0},
        '{ROW_CFG,  CFG_COEF, 19'h40000,  0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_SINE, 19'h20000,  0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_POFF, 19'h8000,   0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_BLEN, 19'd0,      0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd40000, 16'd32768, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd0,     16'd0,     0, 0, 0},
        '{ROW_CFG,  CFG_BLEN, 19'd6,      0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd30000, 16'd30000, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd32768, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd777,   16'd16384, 0, 0, 0},
        // lower the length below the count already taken
        '{ROW_CFG,  CFG_BLEN, 19'd2,      0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd5000,  16'd32768, 0, 0, 0},
        '{ROW_CFG,  CFG_COEF, 19'h20000,  0, 0, 0, 0, 0},
        '{ROW_CFG,  CFG_BLEN, 19'h7FFFF,  0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd32768, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd32768, 0, 0, 0},
        '{ROW_CFG,  CFG_BLEN, 19'd1,      0, 0, 0, 0, 0},
        '{ROW_ITEM, CFG_COEF, 19'd0,      16'd65535, 16'd32768, 0, 0, 0}
    };

    // receiver side
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_bins.size() == 0) begin
                    $error("unexpected result %h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_bins.pop_front();
                    if (o_m_axis_tdata[15:0] !== want[15:0]) begin
                        $error("magnitude: expected %0d, got %0d",
                               want[15:0], o_m_axis_tdata[15:0]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[31:16] !== want[31:16]) begin
                        $error("phase: expected %0d, got %0d",
                               $signed(want[31:16]), $signed(o_m_axis_tdata[31:16]));
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        bit in_cfg;
        int len, count, phase_sel;
        in_cfg = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                if (!in_cfg) drain();
                reg_write(script[k].idx, script[k].val);
                in_cfg = 1'b1;
            end else begin
                if (in_cfg) reg_done();
                in_cfg = 1'b0;
                send_sample(script[k].smp, script[k].wgt, script[k].typed,
                            {script[k].ph, script[k].mag});
            end
        end

        for (int g = 0; g < 64; g++) begin
            phase_sel = g % 4;
            send_idle_pct  = (phase_sel == 1) ? 76 : (phase_sel == 3) ? 14 : 0;
            recv_stall_pct = (phase_sel == 2) ? 76 : (phase_sel == 3) ? 14 : 0;
            drain();
            reg_write(CFG_COEF, rand_reg(CFG_COEF));
            reg_write(CFG_SINE, rand_reg(CFG_SINE));
            reg_write(CFG_POFF, rand_reg(CFG_POFF));
            reg_write(CFG_BLEN, rand_reg(CFG_BLEN));
            reg_done();
            len = (bin_len == 0) ? 1 : ((bin_len > 1024) ? 1024 : int'(bin_len));
            count = len * $urandom_range(3, 1) + $urandom_range(1, 0);
            if (count > 30) count = 30;
            for (int k = 0; k < count; k++)
                send_sample(16'($urandom), rand_weight(), 1'b0, '0);
        end

        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
